@@ hdl/q2e_pkg.sv @@
// Package for the quaternion to Euler angle converter.
// Holds working-format constants, the arctangent table and shared types.
// Depends on nothing.
package q2e_pkg;

    localparam int WORK_FRAC   = 30;
    // Working width: numerators/denominators reach about 2^35, CORDIC growth adds 2 bits.
    localparam int WORK_W      = 40;
    localparam int ANG_W       = 20;
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = 5;
    localparam int SQ_W        = 62;
    localparam int ROOT_W      = 32;

    localparam logic signed [ANG_W-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [ANG_W-1:0] PI_Q13      = 20'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 20'sd12868;

    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic signed [ANG_W-1:0]  angle_t;

    // One CORDIC lane as it travels through the pipeline.
    typedef struct packed {
        work_t  x;
        work_t  y;
        angle_t z;
        logic   zero;
    } lane_t;

    // atan(2^-i) with 16 fraction bits, rounded to nearest.
    function automatic angle_t atan_entry(input logic [IDX_W-1:0] idx);
        angle_t r;
        begin
            case (idx)
                5'd0:  r = 20'sd51472;
                5'd1:  r = 20'sd30386;
                5'd2:  r = 20'sd16055;
                5'd3:  r = 20'sd8150;
                5'd4:  r = 20'sd4091;
                5'd5:  r = 20'sd2047;
                5'd6:  r = 20'sd1024;
                5'd7:  r = 20'sd512;
                5'd8:  r = 20'sd256;
                5'd9:  r = 20'sd128;
                5'd10: r = 20'sd64;
                5'd11: r = 20'sd32;
                5'd12: r = 20'sd16;
                5'd13: r = 20'sd8;
                5'd14: r = 20'sd4;
                5'd15: r = 20'sd2;
                5'd16: r = 20'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Pre-rotation into the right half plane.
    function automatic lane_t lane_start(input work_t y, input work_t x);
        lane_t l;
        begin
            l.zero = (x == '0) && (y == '0);
            if (x < 0)
            begin
                l.x = -x;
                l.y = -y;
                l.z = (y >= 0) ? PI_Q16 : -PI_Q16;
            end
            else
            begin
                l.x = x;
                l.y = y;
                l.z = '0;
            end
            return l;
        end
    endfunction

    function automatic lane_t lane_rotate(input lane_t l, input logic [IDX_W-1:0] s);
        lane_t r;
        work_t dx;
        work_t dy;
        begin
            r = l;
            dx = l.y >>> s;
            dy = l.x >>> s;
            if (l.y >= 0)
            begin
                r.x = l.x + dx;
                r.y = l.y - dy;
                r.z = l.z + atan_entry(s);
            end
            else
            begin
                r.x = l.x - dx;
                r.y = l.y + dy;
                r.z = l.z - atan_entry(s);
            end
            return r;
        end
    endfunction

    // Final rounding to 13 fraction bits, then clamp.
    function automatic angle_t lane_finish(input lane_t l, input angle_t lim);
        angle_t a;
        begin
            a = (l.z + 20'sd4) >>> 3;
            if (l.zero)
                a = '0;
            if (a > lim)
                a = lim;
            else if (a < -lim)
                a = -lim;
            return a;
        end
    endfunction

endpackage

@@ hdl/q2e_if.sv @@
// Valid/ready channel interfaces for the quaternion converter.
// Depends on nothing.
interface q2e_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_saturated;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                    output ready);
endinterface

@@ hdl/q2e_isqrt_stage.sv @@
// One registered step of the restoring square root (floor), two result bits per stage.
// Depends on q2e_pkg.
module q2e_isqrt_stage #(
    parameter int BIT_HI = 31
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [q2e_pkg::SQ_W+1:0]          rem_in,
    input  logic [q2e_pkg::SQ_W+1:0]          res_in,
    output logic [q2e_pkg::SQ_W+1:0]          rem_out,
    output logic [q2e_pkg::SQ_W+1:0]          res_out
);
    localparam int W = q2e_pkg::SQ_W + 2;
    logic [W-1:0] rem_next;
    logic [W-1:0] res_next;
    logic [W-1:0] rem_reg;
    logic [W-1:0] res_reg;

    always_comb
    begin
        logic [W-1:0] v;
        logic [W-1:0] r;
        logic [W-1:0] b;
        v = rem_in;
        r = res_in;
        for (int k = BIT_HI; k > BIT_HI - 2; k--)
        begin
            b = '0;
            if (k >= 0)
            begin
                b[2*k] = 1'b1;
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
            end
        end
        rem_next = v;
        res_next = r;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign rem_out = rem_reg;
    assign res_out = res_reg;
endmodule

@@ hdl/quaternion_to_euler_angles.sv @@
// Quaternion to roll/pitch/yaw converter, fully pipelined.
// Stages in order: products, sums, 16 square-root stages, setup, one CORDIC stage per
// step, rounding into the output register. Throughput: one item per cycle;
// a stall holds every stage. Reset clears only the valid bits.
// Depends on q2e_pkg, q2e_if and q2e_isqrt_stage.
module quaternion_to_euler_angles #(
    parameter int ANGLE_STEPS = 16
) (
    input logic      clk,
    input logic      rst_n,
    q2e_in_if.sink   in_ch,
    q2e_out_if.source out_ch
);
    localparam int SQ_STAGES = 16;
    // Valid bits for every stage ahead of the output register, which has its own.
    localparam int DEPTH = 2 + SQ_STAGES + 1 + ANGLE_STEPS;
    localparam int WF = q2e_pkg::WORK_FRAC;
    localparam int SW = q2e_pkg::SQ_W + 2;

    logic [DEPTH-1:0] vld_reg;
    logic             en;
    logic             out_vld_reg;

    assign en = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[DEPTH-2:0], in_ch.valid};
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    // Stage 1: products.
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [31:0] p_wz_reg, p_xy_reg, p_wy_reg, p_zx_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wx_reg <= in_ch.quat_w * in_ch.quat_x;
            p_yz_reg <= in_ch.quat_y * in_ch.quat_z;
            p_xx_reg <= in_ch.quat_x * in_ch.quat_x;
            p_yy_reg <= in_ch.quat_y * in_ch.quat_y;
            p_zz_reg <= in_ch.quat_z * in_ch.quat_z;
            p_wz_reg <= in_ch.quat_w * in_ch.quat_z;
            p_xy_reg <= in_ch.quat_x * in_ch.quat_y;
            p_wy_reg <= in_ch.quat_w * in_ch.quat_y;
            p_zx_reg <= in_ch.quat_z * in_ch.quat_x;
        end
    end

    // Stage 2: sums in 28 fraction bits, widened by 2 into the working format.
    q2e_pkg::work_t sr_reg, cr_reg, sy_reg, cy_reg, sp_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg <= (q2e_pkg::WORK_W'(p_wx_reg) + q2e_pkg::WORK_W'(p_yz_reg)) <<< 3;
            cr_reg <= ((q2e_pkg::work_t'(1) <<< 28)
                       - ((q2e_pkg::WORK_W'(p_xx_reg) + q2e_pkg::WORK_W'(p_yy_reg)) <<< 1)) <<< 2;
            sy_reg <= (q2e_pkg::WORK_W'(p_wz_reg) + q2e_pkg::WORK_W'(p_xy_reg)) <<< 3;
            cy_reg <= ((q2e_pkg::work_t'(1) <<< 28)
                       - ((q2e_pkg::WORK_W'(p_yy_reg) + q2e_pkg::WORK_W'(p_zz_reg)) <<< 1)) <<< 2;
            sp_reg <= (q2e_pkg::WORK_W'(p_wy_reg) - q2e_pkg::WORK_W'(p_zx_reg)) <<< 3;
        end
    end

    // Square-root pipeline for pitch; roll, yaw and sp ride along.
    logic           sat_w;
    logic [SW-1:0]  rem0;
    logic [SW-1:0]  sq_rem [0:SQ_STAGES];
    logic [SW-1:0]  sq_res [0:SQ_STAGES];
    q2e_pkg::work_t dl_sr [0:SQ_STAGES];
    q2e_pkg::work_t dl_cr [0:SQ_STAGES];
    q2e_pkg::work_t dl_sy [0:SQ_STAGES];
    q2e_pkg::work_t dl_cy [0:SQ_STAGES];
    q2e_pkg::work_t dl_sp [0:SQ_STAGES];
    logic           dl_sat [0:SQ_STAGES];

    always_comb
    begin
        logic signed [2*q2e_pkg::WORK_W-1:0] sq;
        sat_w = (sp_reg >= (q2e_pkg::work_t'(1) <<< WF))
             || (sp_reg <= -(q2e_pkg::work_t'(1) <<< WF));
        // |sp| < 2^30 when not saturated, so the square fits in 60 bits.
        sq = $signed(sp_reg[31:0]) * $signed(sp_reg[31:0]);
        rem0 = (SW'(1) << (2*WF)) - SW'(sq[SW-1:0]);
        if (sat_w)
            rem0 = '0;
    end

    assign sq_rem[0] = rem0;
    assign sq_res[0] = '0;
    assign dl_sr[0] = sr_reg;
    assign dl_cr[0] = cr_reg;
    assign dl_sy[0] = sy_reg;
    assign dl_cy[0] = cy_reg;
    assign dl_sp[0] = sp_reg;
    assign dl_sat[0] = sat_w;

    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_sqrt
        q2e_pkg::work_t sr_reg_d, cr_reg_d, sy_reg_d, cy_reg_d, sp_reg_d;
        logic sat_reg_d;
        q2e_isqrt_stage #(.BIT_HI(31 - 2*g)) u_stage (
            .clk     (clk),
            .en      (en),
            .rem_in  (sq_rem[g]),
            .res_in  (sq_res[g]),
            .rem_out (sq_rem[g+1]),
            .res_out (sq_res[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_reg_d  <= dl_sr[g];
                cr_reg_d  <= dl_cr[g];
                sy_reg_d  <= dl_sy[g];
                cy_reg_d  <= dl_cy[g];
                sp_reg_d  <= dl_sp[g];
                sat_reg_d <= dl_sat[g];
            end
        end
        assign dl_sr[g+1] = sr_reg_d;
        assign dl_cr[g+1] = cr_reg_d;
        assign dl_sy[g+1] = sy_reg_d;
        assign dl_cy[g+1] = cy_reg_d;
        assign dl_sp[g+1] = sp_reg_d;
        assign dl_sat[g+1] = sat_reg_d;
    end

    // Setup stage: pre-rotate three vectors.
    q2e_pkg::lane_t lr [0:ANGLE_STEPS];
    q2e_pkg::lane_t lp [0:ANGLE_STEPS];
    q2e_pkg::lane_t ly [0:ANGLE_STEPS];
    logic           ls [0:ANGLE_STEPS];
    logic           lsg [0:ANGLE_STEPS];
    q2e_pkg::lane_t lr0_reg, lp0_reg, ly0_reg;
    logic           ls0_reg, lsg0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lr0_reg  <= q2e_pkg::lane_start(dl_sr[SQ_STAGES], dl_cr[SQ_STAGES]);
            ly0_reg  <= q2e_pkg::lane_start(dl_sy[SQ_STAGES], dl_cy[SQ_STAGES]);
            lp0_reg  <= q2e_pkg::lane_start(dl_sp[SQ_STAGES],
                                            q2e_pkg::WORK_W'(sq_res[SQ_STAGES][31:0]));
            ls0_reg  <= dl_sat[SQ_STAGES];
            lsg0_reg <= dl_sp[SQ_STAGES] > 0;
        end
    end
    assign lr[0] = lr0_reg;
    assign lp[0] = lp0_reg;
    assign ly[0] = ly0_reg;
    assign ls[0] = ls0_reg;
    assign lsg[0] = lsg0_reg;

    for (genvar i = 0; i < ANGLE_STEPS; i++)
    begin : g_cordic
        localparam logic [q2e_pkg::IDX_W-1:0] SH = q2e_pkg::IDX_W'(i);
        q2e_pkg::lane_t r_reg, p_reg, y_reg;
        logic s_reg, g_reg;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg <= q2e_pkg::lane_rotate(lr[i], SH);
                p_reg <= q2e_pkg::lane_rotate(lp[i], SH);
                y_reg <= q2e_pkg::lane_rotate(ly[i], SH);
                s_reg <= ls[i];
                g_reg <= lsg[i];
            end
        end
        assign lr[i+1] = r_reg;
        assign lp[i+1] = p_reg;
        assign ly[i+1] = y_reg;
        assign ls[i+1] = s_reg;
        assign lsg[i+1] = g_reg;
    end

    // Output register.
    q2e_pkg::angle_t roll_a, pitch_a, yaw_a;
    logic signed [15:0] roll_reg, yaw_reg;
    logic signed [14:0] pitch_reg;
    logic               sat_reg;
    always_comb
    begin
        roll_a = q2e_pkg::lane_finish(lr[ANGLE_STEPS], q2e_pkg::PI_Q13);
        yaw_a  = q2e_pkg::lane_finish(ly[ANGLE_STEPS], q2e_pkg::PI_Q13);
        if (ls[ANGLE_STEPS])
            pitch_a = lsg[ANGLE_STEPS] ? q2e_pkg::HALF_PI_Q13 : -q2e_pkg::HALF_PI_Q13;
        else
            pitch_a = q2e_pkg::lane_finish(lp[ANGLE_STEPS], q2e_pkg::HALF_PI_Q13);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_a[15:0];
            pitch_reg <= pitch_a[14:0];
            yaw_reg   <= yaw_a[15:0];
            sat_reg   <= ls[ANGLE_STEPS];
        end
    end

    assign out_ch.valid           = out_vld_reg;
    assign out_ch.roll_angle      = roll_reg;
    assign out_ch.pitch_angle     = pitch_reg;
    assign out_ch.yaw_angle       = yaw_reg;
    assign out_ch.pitch_saturated = sat_reg;

    // A result waiting on a stalled sink must not be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ch.ready |=> out_vld_reg && $stable(roll_reg) && $stable(yaw_reg))
        else $error("stalled result changed");
    // Input is taken whenever the output slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> in_ch.ready)
        else $error("input blocked with free output");
    // A saturated pitch is always exactly plus or minus pi/2.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && sat_reg |-> pitch_reg == 15'sd12868 || pitch_reg == -15'sd12868)
        else $error("saturated pitch not at pi/2");
endmodule
